// ===== design/ccn_pkg.sv =====
// Shared constants, types and saturation helpers for the color channel calibrator.
package ccn_pkg;

    localparam int RAW_W         = 16;
    localparam int COLOR_W       = 8;
    localparam int WHITE_W       = 7;
    localparam int WORD_W        = 64;
    localparam int NUM_CH        = 4;
    localparam int CAL_REGS      = 2 * NUM_CH;
    localparam int CFG_IDX_W     = $clog2(CAL_REGS);
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic signed [WORD_W-1:0] SPAN_COLOR = WORD_W'(255);
    localparam logic signed [WORD_W-1:0] SPAN_WHITE = WORD_W'(100);
    localparam logic signed [WORD_W-1:0] SUM_LIMIT  = WORD_W'(10);
    localparam logic signed [WORD_W-1:0] PERCENT    = WORD_W'(100);
    localparam logic signed [WORD_W-1:0] COLOR_MAX  = WORD_W'(255);
    localparam logic signed [WORD_W-1:0] WHITE_MAX  = WORD_W'(100);

    localparam logic [RAW_W-1:0]     CAL_LOW_INIT   = '0;
    localparam logic [RAW_W-1:0]     CAL_HIGH_INIT  = '1;

    // One classified sample set: offsets from low and calibration runs.
    typedef struct packed {
        logic [NUM_CH-1:0][RAW_W:0] num;
        logic [NUM_CH-1:0][RAW_W:0] run;
        logic                       err;
    } t_job;

    function automatic logic [COLOR_W-1:0] sat_color(input logic signed [WORD_W-1:0] v);
        logic [COLOR_W-1:0] r;
        if (v < 0) r = '0;
        else if (v > COLOR_MAX) r = '1;
        else r = v[COLOR_W-1:0];
        return r;
    endfunction

    function automatic logic [WHITE_W-1:0] sat_white(input logic signed [WORD_W-1:0] v);
        logic [WHITE_W-1:0] r;
        if (v < 0) r = '0;
        else if (v > WHITE_MAX) r = WHITE_MAX[WHITE_W-1:0];
        else r = v[WHITE_W-1:0];
        return r;
    endfunction

endpackage

// ===== design/color_channel_calibrate_normalize.sv =====
// Up to thirteen divisions share one 64-bit serial divider: seven always, plus three more for
// each color sum that exceeds ten. A calibration error job skips every division and goes
// straight to the output register.
// The back end takes a new sample set only after the last one has reached the output register.
// The two-entry queue and the output register let input and output stall independently.
// Synchronous active-low reset clears control; low registers load 0, high registers 65535.
module color_channel_calibrate_normalize #(
    parameter int FRAC_BITS = ccn_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ccn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ccn_pkg::RAW_W-1:0]         i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [ccn_pkg::RAW_W-1:0]         i_raw_red,
    input  logic [ccn_pkg::RAW_W-1:0]         i_raw_green,
    input  logic [ccn_pkg::RAW_W-1:0]         i_raw_blue,
    input  logic [ccn_pkg::RAW_W-1:0]         i_raw_white,
    output logic                              empty,
    input  logic                              pop,
    output logic [ccn_pkg::COLOR_W-1:0]       o_out_red,
    output logic [ccn_pkg::COLOR_W-1:0]       o_out_green,
    output logic [ccn_pkg::COLOR_W-1:0]       o_out_blue,
    output logic [ccn_pkg::WHITE_W-1:0]       o_out_white,
    output logic                              o_cal_error
);

    logic [ccn_pkg::NUM_CH-1:0][ccn_pkg::RAW_W-1:0] raw;
    logic          take;
    logic          avail;
    ccn_pkg::t_job job;

    assign o_cfg_ready = 1'b1;
    assign raw = {i_raw_white, i_raw_blue, i_raw_green, i_raw_red};

    ccn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_raw       (raw),
        .o_full      (full),
        .i_take      (take),
        .o_avail     (avail),
        .o_job       (job)
    );

    ccn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_job   (job),
        .o_take  (take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_red   (o_out_red),
        .o_green (o_out_green),
        .o_blue  (o_out_blue),
        .o_white (o_out_white),
        .o_err   (o_cal_error)
    );

endmodule

// ===== design/ccn_div.sv =====
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
module ccn_div #(
    parameter int WIDTH = ccn_pkg::WORD_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [WIDTH-1:0] i_num,
    input  logic signed [WIDTH-1:0] i_den,
    output logic                    o_done,
    output logic signed [WIDTH-1:0] o_quot
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dmag;
    logic             r_neg;

    logic [WIDTH:0]   shifted;
    logic             fits;

    assign shifted = {r_rem, r_quo[WIDTH-1]};
    assign fits    = shifted >= {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(WIDTH - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num[WIDTH-1] ? WIDTH'(-i_num) : i_num;
                r_dmag <= i_den[WIDTH-1] ? WIDTH'(-i_den) : i_den;
                r_neg  <= i_num[WIDTH-1] ^ i_den[WIDTH-1];
            end else if (r_busy) begin
                r_rem <= fits ? WIDTH'(shifted - {1'b0, r_dmag}) : shifted[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? WIDTH'(-$signed(r_quo)) : $signed(r_quo);

endmodule

// ===== design/ccn_front.sv =====
// Front end: calibration registers, sample classification and the job queue.
module ccn_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [ccn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ccn_pkg::RAW_W-1:0]           i_cfg_data,
    input  logic                                i_push,
    input  logic [ccn_pkg::NUM_CH-1:0][ccn_pkg::RAW_W-1:0] i_raw,
    output logic                                o_full,
    input  logic                                i_take,
    output logic                                o_avail,
    output ccn_pkg::t_job                       o_job
);

    localparam int PTR_W = $clog2(ccn_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ccn_pkg::QUEUE_DEPTH + 1);

    logic [ccn_pkg::RAW_W-1:0] r_cal [ccn_pkg::CAL_REGS];
    ccn_pkg::t_job             r_q   [ccn_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]          r_wr;
    logic [PTR_W-1:0]          r_rd;
    logic [CNT_W-1:0]          r_cnt;

    ccn_pkg::t_job job;
    logic          do_push;
    logic          do_pop;

    always_comb begin
        job = '0;
        for (int k = 0; k < ccn_pkg::NUM_CH; k++) begin
            job.num[k] = {1'b0, i_raw[k]} - {1'b0, r_cal[2*k]};
            job.run[k] = {1'b0, r_cal[2*k+1]} - {1'b0, r_cal[2*k]};
            if (r_cal[2*k] == r_cal[2*k+1]) job.err = 1'b1;
        end
    end

    assign o_full  = r_cnt == CNT_W'(ccn_pkg::QUEUE_DEPTH);
    assign o_avail = r_cnt != '0;
    assign o_job   = r_q[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ccn_pkg::CAL_REGS; i++) begin
                r_cal[i] <= i[0] ? ccn_pkg::CAL_HIGH_INIT : ccn_pkg::CAL_LOW_INIT;
            end
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_valid) r_cal[i_cfg_index] <= i_cfg_data;
            if (do_push) begin
                r_q[r_wr] <= job;
                r_wr      <= r_wr + 1'b1;
            end
            if (do_pop) r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== design/ccn_back.sv =====
// Back end: sequencer that runs the mapping, normalization and stretch on the divider.
module ccn_back #(
    parameter int FRAC_BITS = ccn_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_avail,
    input  ccn_pkg::t_job                 i_job,
    output logic                          o_take,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [ccn_pkg::COLOR_W-1:0]   o_red,
    output logic [ccn_pkg::COLOR_W-1:0]   o_green,
    output logic [ccn_pkg::COLOR_W-1:0]   o_blue,
    output logic [ccn_pkg::WHITE_W-1:0]   o_white,
    output logic                          o_err
);

    localparam int W = ccn_pkg::WORD_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAP_GO, ST_MAP_WAIT, ST_SUM, ST_Q_GO, ST_Q_WAIT, ST_MIN,
        ST_T_GO, ST_T_WAIT, ST_TSUM, ST_O_GO, ST_O_WAIT, ST_EMIT
    } t_state;

    t_state              r_state;
    ccn_pkg::t_job       r_job;
    logic [1:0]          r_idx;
    logic signed [W-1:0] r_m [ccn_pkg::NUM_CH];
    logic signed [W-1:0] r_q [3];
    logic signed [W-1:0] r_t [3];
    logic [ccn_pkg::COLOR_W-1:0] r_o [3];
    logic signed [W-1:0] r_sum;
    logic signed [W-1:0] r_mnsh;
    logic signed [W-1:0] r_dd;
    logic                r_div_start;
    logic signed [W-1:0] r_div_num;
    logic signed [W-1:0] r_div_den;
    logic                r_out_valid;
    logic [ccn_pkg::COLOR_W-1:0] r_out_red;
    logic [ccn_pkg::COLOR_W-1:0] r_out_green;
    logic [ccn_pkg::COLOR_W-1:0] r_out_blue;
    logic [ccn_pkg::WHITE_W-1:0] r_out_white;
    logic                r_out_err;

    logic                div_done;
    logic signed [W-1:0] div_quot;
    logic signed [W-1:0] map_num;
    logic signed [W-1:0] map_den;
    logic signed [W-1:0] minq;
    logic signed [W-1:0] mn_floor;
    logic signed [W-1:0] mn;
    logic signed [W-1:0] stretch_den;
    logic signed [W-1:0] q_off;

    ccn_div #(.WIDTH(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        map_num = W'($signed(r_job.num[r_idx]));
        map_num = map_num * ((r_idx == 2'd3) ? ccn_pkg::SPAN_WHITE : ccn_pkg::SPAN_COLOR);
        map_den = W'($signed(r_job.run[r_idx]));
        minq = r_q[0];
        if (r_q[1] < minq) minq = r_q[1];
        if (r_q[2] < minq) minq = r_q[2];
        mn_floor = minq >>> FRAC_BITS;
        // The shift floors; a negative value with a fraction moves up toward zero.
        mn = (minq < 0 && (|minq[FRAC_BITS-1:0])) ? mn_floor + W'(1) : mn_floor;
        stretch_den = ccn_pkg::COLOR_MAX - mn;
        if (stretch_den < 1) stretch_den = W'(1);
        q_off = (r_q[r_idx] - r_mnsh) * ccn_pkg::COLOR_MAX;
    end

    assign o_take = (r_state == ST_IDLE) && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A division starts in the cycle after each go step that needs one.
            r_div_start <= (r_state == ST_MAP_GO) || (r_state == ST_T_GO) ||
                           (((r_state == ST_Q_GO) || (r_state == ST_O_GO)) &&
                            (r_sum > ccn_pkg::SUM_LIMIT));
            r_out_valid <= (r_state == ST_EMIT) || (r_out_valid && !i_pop);
            case (r_state)
                ST_IDLE: begin
                    if (i_avail) begin
                        r_job   <= i_job;
                        r_idx   <= '0;
                        r_state <= i_job.err ? ST_EMIT : ST_MAP_GO;
                    end
                end
                ST_MAP_GO: begin
                    r_div_num   <= map_num;
                    r_div_den   <= map_den;
                    r_state     <= ST_MAP_WAIT;
                end
                ST_MAP_WAIT: begin
                    if (div_done) begin
                        r_m[r_idx] <= div_quot;
                        if (r_idx == 2'd3) begin
                            r_state <= ST_SUM;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_MAP_GO;
                        end
                    end
                end
                ST_SUM: begin
                    r_sum   <= r_m[0] + r_m[1] + r_m[2];
                    r_idx   <= '0;
                    r_state <= ST_Q_GO;
                end
                ST_Q_GO: begin
                    if (r_sum > ccn_pkg::SUM_LIMIT) begin
                        r_div_num   <= (r_m[r_idx] * ccn_pkg::PERCENT) <<< FRAC_BITS;
                        r_div_den   <= r_sum;
                        r_state     <= ST_Q_WAIT;
                    end else begin
                        r_q[r_idx] <= r_m[r_idx] <<< FRAC_BITS;
                        if (r_idx == 2'd2) begin
                            r_state <= ST_MIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_Q_WAIT: begin
                    if (div_done) begin
                        r_q[r_idx] <= div_quot;
                        if (r_idx == 2'd2) begin
                            r_state <= ST_MIN;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_Q_GO;
                        end
                    end
                end
                ST_MIN: begin
                    r_mnsh  <= mn <<< FRAC_BITS;
                    r_dd    <= stretch_den <<< FRAC_BITS;
                    r_idx   <= '0;
                    r_state <= ST_T_GO;
                end
                ST_T_GO: begin
                    r_div_num   <= q_off;
                    r_div_den   <= r_dd;
                    r_state     <= ST_T_WAIT;
                end
                ST_T_WAIT: begin
                    if (div_done) begin
                        r_t[r_idx] <= div_quot;
                        if (r_idx == 2'd2) begin
                            r_state <= ST_TSUM;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_T_GO;
                        end
                    end
                end
                ST_TSUM: begin
                    r_sum   <= r_t[0] + r_t[1] + r_t[2];
                    r_idx   <= '0;
                    r_state <= ST_O_GO;
                end
                ST_O_GO: begin
                    if (r_sum > ccn_pkg::SUM_LIMIT) begin
                        r_div_num   <= r_t[r_idx] * ccn_pkg::PERCENT;
                        r_div_den   <= r_sum;
                        r_state     <= ST_O_WAIT;
                    end else begin
                        r_o[r_idx] <= ccn_pkg::sat_color(r_t[r_idx]);
                        if (r_idx == 2'd2) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_O_WAIT: begin
                    if (div_done) begin
                        r_o[r_idx] <= ccn_pkg::sat_color(div_quot);
                        if (r_idx == 2'd2) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_O_GO;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_pop) begin
                        r_out_err   <= r_job.err;
                        r_out_red   <= r_job.err ? '0 : r_o[0];
                        r_out_green <= r_job.err ? '0 : r_o[1];
                        r_out_blue  <= r_job.err ? '0 : r_o[2];
                        r_out_white <= r_job.err ? '0 : ccn_pkg::sat_white(r_m[3]);
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_empty = !r_out_valid;
    assign o_red   = r_out_red;
    assign o_green = r_out_green;
    assign o_blue  = r_out_blue;
    assign o_white = r_out_white;
    assign o_err   = r_out_err;

    a_err_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_avail && i_job.err) |=> r_state == ST_EMIT)
        else $error("calibration error job did not go straight to emit");

    a_emit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_out_valid) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("emit with a free output register did not load it");

    a_div_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == ST_MAP_WAIT || r_state == ST_Q_WAIT ||
                         r_state == ST_T_WAIT || r_state == ST_O_WAIT))
        else $error("divider started outside a wait step");

endmodule
